// ===== rtl/totp_pkg.sv =====
`default_nettype none
package totp_pkg;
    localparam int unsigned SYNC_THRESHOLD = 32'd1700000000;
    localparam logic [31:0] SHA_H0 = 32'h67452301;
    localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_H3 = 32'h10325476;
    localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;

    localparam logic [2:0] ST_MATCH     = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_UNSYNCED  = 3'd2;
    localparam logic [2:0] ST_NO_KEY    = 3'd3;
    localparam logic [2:0] ST_NO_MATCH  = 3'd4;

    localparam logic [2:0] CFG_KEY_LOW  = 3'd0;
    localparam logic [2:0] CFG_KEY_MID  = 3'd1;
    localparam logic [2:0] CFG_KEY_HIGH = 3'd2;
    localparam logic [2:0] CFG_KEY_LEN  = 3'd3;
    localparam logic [2:0] CFG_STEP     = 3'd4;
    localparam logic [2:0] CFG_SKEW     = 3'd5;

    // which 64-byte block the compression unit consumes
    typedef enum logic [1:0] {
        BLK_IPAD,
        BLK_INNER,
        BLK_OPAD,
        BLK_OUTER
    } blk_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_WINDOW,
        S_BLK_START,
        S_BLK_RUN,
        S_BLK_DONE,
        S_TRUNC,
        S_MOD,
        S_COMPARE,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_step;
        logic     win_init;
        logic     step_next;
        logic     blk_start;
        blk_sel_t blk;
        logic     round;
        logic     blk_finish;
        logic     trunc;
        logic     mod_step;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       early_fail;
        logic [2:0] early_status;
        logic       div_done;
        logic       round_last;
        logic       mod_done;
        logic       match;
        logic       at_hi;
    } dp_status_t;
endpackage
`default_nettype wire

// ===== rtl/totp_if.sv =====
`default_nettype none
interface totp_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] claimed_code;
    logic        code_well_formed;
    logic [63:0] unix_seconds;
    modport source (output valid, claimed_code, code_well_formed, unix_seconds, input ready);
    modport sink (input valid, claimed_code, code_well_formed, unix_seconds, output ready);
endinterface

interface totp_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [2:0] status;
    modport source (output valid, accepted, status, input ready);
    modport sink (input valid, accepted, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/totp_ctrl.sv =====
`default_nettype none
module totp_ctrl
    import totp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic out_busy,
    input  wire dp_status_t st,
    output logic      in_ready,
    output ctrl_cmd_t cmd
);
    ctrl_state_t state_reg, state_next;
    blk_sel_t    blk_reg, blk_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            blk_reg   <= BLK_IPAD;
        end
        else
        begin
            state_reg <= state_next;
            blk_reg   <= blk_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        unique case (state_reg)
            S_IDLE:      if (in_fire) state_next = S_CHECK;
            S_CHECK:     state_next = st.early_fail ? S_OUT : S_DIV;
            S_DIV:       if (st.div_done) state_next = S_WINDOW;
            S_WINDOW:
            begin
                blk_next   = BLK_IPAD;
                state_next = S_BLK_START;
            end
            S_BLK_START: state_next = S_BLK_RUN;
            S_BLK_RUN:   if (st.round_last) state_next = S_BLK_DONE;
            S_BLK_DONE:
            begin
                if (blk_reg == BLK_OUTER)
                    state_next = S_TRUNC;
                else
                begin
                    blk_next   = blk_sel_t'(blk_reg + 2'd1);
                    state_next = S_BLK_START;
                end
            end
            S_TRUNC:     state_next = S_MOD;
            S_MOD:       if (st.mod_done) state_next = S_COMPARE;
            S_COMPARE:
            begin
                if (st.match || st.at_hi)
                    state_next = S_OUT;
                else
                begin
                    blk_next   = BLK_IPAD;
                    state_next = S_BLK_START;
                end
            end
            S_OUT:       if (!out_busy) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.blk      = blk_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            S_CHECK:     cmd.div_start = !st.early_fail;
            S_DIV:       cmd.div_step = 1'b1;
            S_WINDOW:    cmd.win_init = 1'b1;
            S_BLK_START: cmd.blk_start = 1'b1;
            S_BLK_RUN:   cmd.round = 1'b1;
            S_BLK_DONE:  cmd.blk_finish = 1'b1;
            S_TRUNC:     cmd.trunc = 1'b1;
            S_MOD:       cmd.mod_step = 1'b1;
            S_COMPARE:   cmd.step_next = !(st.match || st.at_hi);
            S_OUT:       cmd.out_load = !out_busy;
            default:     ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/totp_dp.sv =====
`default_nettype none
module totp_dp
    import totp_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 20,
    parameter int CODE_DIGITS   = 6
)
(
    input  wire logic        clk,
    input  wire ctrl_cmd_t   cmd,
    input  wire logic [19:0] claimed_code,
    input  wire logic        code_well_formed,
    input  wire logic [63:0] unix_seconds,
    input  wire logic [159:0] key_bits,
    input  wire logic [4:0]  key_length,
    input  wire logic [11:0] step_seconds,
    input  wire logic [2:0]  skew_steps,
    output dp_status_t       st,
    output logic             res_accepted,
    output logic [2:0]       res_status
);
    localparam logic [63:0] MODULUS = 64'(10 ** CODE_DIGITS);
    // reciprocal that gives the exact quotient of any 31-bit truncated value
    localparam int unsigned MOD_SHIFT = 31 + $clog2(10 ** CODE_DIGITS);
    localparam logic [31:0] MOD_RECIP =
        32'(((64'd1 << MOD_SHIFT) + MODULUS - 64'd1) / MODULUS);

    logic [19:0]  code_reg;
    logic         well_reg;
    logic [63:0]  now_reg;
    logic [11:0]  period_reg;
    logic [63:0]  quo_reg;
    logic [11:0]  rem_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  step_reg, hi_reg;
    logic [159:0] inner_reg;
    logic [31:0]  h_reg [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  w_reg [16];
    logic [63:0]  bin_reg;
    logic [63:0]  prod_reg;
    logic         mphase_reg;

    // key padded to one block
    logic [511:0] key_block;
    logic [4:0]   klen;
    always_comb
    begin
        klen = (key_length > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : key_length;
        key_block = '0;
        for (int i = 0; i < 20; i++)
            if (5'(i) < klen)
                key_block[511 - 8*i -: 8] = key_bits[159 - 8*i -: 8];
    end

    logic [2:0] early_status;
    always_comb
    begin
        if (!well_reg)
            early_status = ST_MALFORMED;
        else if (now_reg <= 64'(SYNC_THRESHOLD))
            early_status = ST_UNSYNCED;
        else if (klen == 5'd0)
            early_status = ST_NO_KEY;
        else
            early_status = ST_NO_MATCH;
    end

    // message block for the current compression
    logic [511:0] msg;
    always_comb
    begin
        unique case (cmd.blk)
            BLK_IPAD:  msg = key_block ^ {64{8'h36}};
            BLK_INNER: msg = {step_reg, 8'h80, 376'd0, 64'd576};
            BLK_OPAD:  msg = key_block ^ {64{8'h5C}};
            default:   msg = {inner_reg, 8'h80, 280'd0, 64'd672};
        endcase
    end

    logic [31:0] f, k, t, wn;
    always_comb
    begin
        if (cnt_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (cnt_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (cnt_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t  = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_reg[0];
        wn = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wn = {wn[30:0], wn[31]};
    end

    logic [159:0] mac;
    assign mac = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};

    logic [12:0] rem_shift;
    assign rem_shift = {rem_reg, quo_reg[63]};

    logic [11:0] mod_quo;
    assign mod_quo = 12'(prod_reg >> MOD_SHIFT);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg <= claimed_code;
            well_reg <= code_well_formed;
            now_reg  <= unix_seconds;
        end
        if (cmd.div_start)
        begin
            period_reg <= (step_seconds == 12'd0) ? 12'd1 : step_seconds;
            quo_reg    <= now_reg;
            rem_reg    <= '0;
            cnt_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit a cycle
            if (rem_shift >= {1'b0, period_reg})
            begin
                rem_reg <= 12'(rem_shift - {1'b0, period_reg});
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[11:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 7'd1;
        end
        if (cmd.win_init)
        begin
            step_reg <= (quo_reg >= 64'(skew_steps)) ? quo_reg - 64'(skew_steps) : 64'd0;
            hi_reg   <= (quo_reg <= ~64'(skew_steps)) ? quo_reg + 64'(skew_steps) : '1;
        end
        if (cmd.step_next)
            step_reg <= step_reg + 64'd1;
        if (cmd.blk_start)
        begin
            if (cmd.blk == BLK_IPAD || cmd.blk == BLK_OPAD)
            begin
                h_reg[0] <= SHA_H0; h_reg[1] <= SHA_H1; h_reg[2] <= SHA_H2;
                h_reg[3] <= SHA_H3; h_reg[4] <= SHA_H4;
                a_reg <= SHA_H0; b_reg <= SHA_H1; c_reg <= SHA_H2;
                d_reg <= SHA_H3; e_reg <= SHA_H4;
            end
            else
            begin
                a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                d_reg <= h_reg[3]; e_reg <= h_reg[4];
            end
            for (int i = 0; i < 16; i++)
                w_reg[i] <= msg[511 - 32*i -: 32];
            cnt_reg <= '0;
        end
        if (cmd.round)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wn;
            cnt_reg <= cnt_reg + 7'd1;
        end
        if (cmd.blk_finish)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
            if (cmd.blk == BLK_INNER)
                inner_reg <= {h_reg[0] + a_reg, h_reg[1] + b_reg, h_reg[2] + c_reg,
                              h_reg[3] + d_reg, h_reg[4] + e_reg};
        end
        if (cmd.trunc)
        begin
            bin_reg    <= {33'd0, 31'(mac[159 - 8*mac[3:0] -: 32])};
            mphase_reg <= 1'b0;
        end
        if (cmd.mod_step)
        begin
            // first phase: quotient by reciprocal; second phase: take off the multiple
            if (!mphase_reg)
                prod_reg <= 64'(bin_reg[30:0]) * 64'(MOD_RECIP);
            else
                bin_reg <= bin_reg - 64'(mod_quo) * MODULUS;
            mphase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (early_status == ST_NO_MATCH && {44'd0, code_reg} == bin_reg)
            begin
                res_accepted <= 1'b1;
                res_status   <= ST_MATCH;
            end
            else
            begin
                res_accepted <= 1'b0;
                res_status   <= early_status;
            end
        end
    end

    always_comb
    begin
        st.early_fail   = (early_status != ST_NO_MATCH);
        st.early_status = early_status;
        st.div_done     = (cnt_reg == 7'd63);
        st.round_last   = (cnt_reg == 7'd79);
        st.mod_done     = mphase_reg;
        st.match        = ({44'd0, code_reg} == bin_reg);
        st.at_hi        = (step_reg == hi_reg);
    end
endmodule
`default_nettype wire

// ===== rtl/totp_code_verifier_unit.sv =====
// TOTP code verifier (HMAC-SHA1, dynamic truncation, decimal code).
// Input channel (in): claimed_code, code_well_formed, unix_seconds; a transfer
// happens when valid and ready are high at a rising clock edge.
// Output channel (out): accepted and status, one result per input transfer.
// Configuration: write cfg_we with cfg_index (0 key low, 1 key mid, 2 key high,
// 3 key length, 4 step seconds, 5 skew steps) and cfg_data, only while idle.
// Sequence: an early reject (malformed, unsynced, no key) goes straight to
// the result. Otherwise the step is found by division, then per window step
// come four SHA-1 compressions, the truncation, the modular reduction and the
// compare, until a match or the last step of the window; then the result is
// loaded. A window has 7 steps at skew 3 and 15 steps at the widest.
// All four compressions of a step run on the shared 80-round compression unit.
// One item is in flight at a time; ready is high only when idle.
// Reset: key cleared, key length 0, step 30 s, skew 3, no result pending.
// A stalled receiver holds the result; the next item is still taken, but its
// result waits until the held one has been transferred.
`default_nettype none
module totp_code_verifier_unit
    import totp_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 20,
    parameter int CODE_DIGITS   = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    totp_in_if.sink          in,
    totp_out_if.source       out,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    logic [63:0] key_low_reg, key_mid_reg;
    logic [31:0] key_high_reg;
    logic [4:0]  key_len_reg;
    logic [11:0] step_reg;
    logic [2:0]  skew_reg;
    logic        out_valid_reg;

    // configuration bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_mid_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
            step_reg     <= 12'd30;
            skew_reg     <= 3'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_MID:  key_mid_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data[31:0];
                CFG_KEY_LEN:  key_len_reg  <= cfg_data[4:0];
                CFG_STEP:     step_reg     <= cfg_data[11:0];
                CFG_SKEW:     skew_reg     <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic       in_fire;
    logic       out_busy;

    assign in_fire  = in.valid && in.ready;
    // hold the verdict while the receiver stalls
    assign out_busy = out_valid_reg && !out.ready;

    totp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_busy),
        .st       (st),
        .in_ready (in.ready),
        .cmd      (cmd)
    );

    totp_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .CODE_DIGITS   (CODE_DIGITS)
    ) u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .claimed_code     (in.claimed_code),
        .code_well_formed (in.code_well_formed),
        .unix_seconds     (in.unix_seconds),
        .key_bits         ({key_low_reg, key_mid_reg, key_high_reg}),
        .key_length       (key_len_reg),
        .step_seconds     (step_reg),
        .skew_steps       (skew_reg),
        .st               (st),
        .res_accepted     (out.accepted),
        .res_status       (out.status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out.ready)
            out_valid_reg <= 1'b0;
    end

    assign out.valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import totp_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 10000000;
    localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    // Row kinds of the directed table
    typedef enum logic [1:0] {
        ROW_CFG,    // register write, block drained first
        ROW_FIXED,  // verdict typed into the table
        ROW_PRED,   // verdict from the predictor
        ROW_HIT     // code taken from the step at an offset from the current one
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] data;
        logic [19:0] code;
        logic        well;
        logic [63:0] now;
        int          offset;
        logic        acc;
        logic [2:0]  status;
    } dir_row_t;

    typedef struct packed {
        logic       acc;
        logic [2:0] status;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    totp_in_if  in_ch ();
    totp_out_if out_ch ();

    totp_code_verifier_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration registers
    logic [63:0] key_lo;
    logic [63:0] key_mid;
    logic [31:0] key_hi;
    logic [4:0]  key_len;
    logic [11:0] step_len;
    logic [2:0]  skew;

    verdict_t verdicts_due[$];
    dir_row_t dir_tab[$];
    int       mismatches;
    int       send_idle;
    int       recv_idle;
    int       hold_reqs;
    int       hold_seen;
    int       hold_left;
    longint unsigned cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: HMAC-SHA1 over the big-endian step, dynamic truncation.
    // ------------------------------------------------------------------
    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] sha1_compress(logic [159:0] h, logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
        {a, b, c, d, e} = h;
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    function automatic logic [19:0] otp_for_step(logic [63:0] step);
        logic [159:0] iv;
        logic [511:0] pad;
        logic [159:0] inner;
        logic [159:0] mac;
        logic [3:0]   off;
        logic [31:0]  bin;
        int           klen;
        iv = {SHA_H0, SHA_H1, SHA_H2, SHA_H3, SHA_H4};
        klen = (key_len > 20) ? 20 : int'(key_len);
        pad = {key_lo, key_mid, key_hi, 352'b0};
        // drop key bytes beyond the length in use
        for (int i = 0; i < 20; i++)
            if (i >= klen)
                pad[511 - 8 * i -: 8] = 8'h00;
        inner = sha1_compress(sha1_compress(iv, pad ^ {64{8'h36}}),
                              {step, 8'h80, 376'b0, 64'd576});
        mac = sha1_compress(sha1_compress(iv, pad ^ {64{8'h5C}}),
                            {inner, 8'h80, 280'b0, 64'd672});
        off = mac[3:0];
        bin = {1'b0, mac[158 - 8 * off -: 7], mac[151 - 8 * off -: 8],
               mac[143 - 8 * off -: 8], mac[135 - 8 * off -: 8]};
        return 20'(bin % 32'd1000000);
    endfunction

    function automatic logic [63:0] current_step(logic [63:0] now);
        return now / ((step_len == 0) ? 64'd1 : 64'(step_len));
    endfunction

    function automatic verdict_t judge_code(logic [19:0] code, logic well, logic [63:0] now);
        logic [63:0] centre, lo, hi, s;
        verdict_t v;
        v = '{acc: 1'b0, status: ST_NO_MATCH};
        if (!well)
            v.status = ST_MALFORMED;
        else if (now <= 64'(SYNC_THRESHOLD))
            v.status = ST_UNSYNCED;
        else if (key_len == 0)
            v.status = ST_NO_KEY;
        else
        begin
            centre = current_step(now);
            lo = (centre >= 64'(skew)) ? centre - 64'(skew) : 64'd0;
            hi = (centre <= T_MAX - 64'(skew)) ? centre + 64'(skew) : T_MAX;
            s = lo;
            forever
            begin
                if (otp_for_step(s) == code)
                begin
                    v = '{acc: 1'b1, status: ST_MATCH};
                    break;
                end
                if (s == hi)
                    break;
                s++;
            end
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Drive side
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_KEY_LOW:  key_lo   = data;
            CFG_KEY_MID:  key_mid  = data;
            CFG_KEY_HIGH: key_hi   = data[31:0];
            CFG_KEY_LEN:  key_len  = data[4:0];
            CFG_STEP:     step_len = data[11:0];
            CFG_SKEW:     skew     = data[2:0];
            default: ;
        endcase
    endtask

    // Drop valid, let every verdict come back, then leave the block idle before returning.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Offer one item; valid stays high after the transfer unless a gap follows.
    task automatic offer(logic [19:0] code, logic well, logic [63:0] now, verdict_t v);
        if ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.claimed_code     <= code;
        in_ch.code_well_formed <= well;
        in_ch.unix_seconds     <= now;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        verdicts_due = {verdicts_due, v};
    endtask

    function automatic dir_row_t row(row_kind_t kind, logic [19:0] code, logic well,
                                     logic [63:0] now, int offset, logic acc,
                                     logic [2:0] status);
        dir_row_t r;
        r = '{kind: kind, idx: CFG_KEY_LOW, data: 64'd0, code: code, well: well, now: now,
              offset: offset, acc: acc, status: status};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [2:0] idx, logic [63:0] data);
        dir_row_t r;
        r = row(ROW_CFG, 20'd0, 1'b0, 64'd0, 0, 1'b0, ST_MATCH);
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    task automatic add_row(dir_row_t r);
        dir_tab = {dir_tab, r};
    endtask

    task automatic fill_table();
        // reset configuration: early rejects only
        add_row(row(ROW_FIXED, 20'd0, 1'b0, 64'd0, 0, 1'b0, ST_MALFORMED));
        add_row(row(ROW_FIXED, 20'hFFFFF, 1'b0, T_MAX, 0, 1'b0, ST_MALFORMED));
        add_row(row(ROW_FIXED, 20'd123456, 1'b1, 64'd1700000000, 0, 1'b0,
                    ST_UNSYNCED));
        add_row(row(ROW_FIXED, 20'd0, 1'b1, 64'd0, 0, 1'b0, ST_UNSYNCED));
        add_row(row(ROW_FIXED, 20'd654321, 1'b1, 64'd1700000001, 0, 1'b0,
                    ST_NO_KEY));
        // published 20-byte test key, 30 s steps, exact step only
        add_row(cfg_row(CFG_KEY_LOW, 64'h3132333435363738));
        add_row(cfg_row(CFG_KEY_MID, 64'h3930313233343536));
        add_row(cfg_row(CFG_KEY_HIGH, 64'h37383930));
        add_row(cfg_row(CFG_KEY_LEN, 64'd20));
        add_row(cfg_row(CFG_STEP, 64'd30));
        add_row(cfg_row(CFG_SKEW, 64'd0));
        add_row(row(ROW_FIXED, 20'd279037, 1'b1, 64'd2000000000, 0, 1'b1, ST_MATCH));
        add_row(row(ROW_FIXED, 20'd353130, 1'b1, 64'd20000000000, 0, 1'b1,
                    ST_MATCH));
        // out-of-range code never matches
        add_row(row(ROW_FIXED, 20'hFFFFF, 1'b1, 64'd2000000000, 0, 1'b0,
                    ST_NO_MATCH));
        add_row(row(ROW_PRED, 20'd999999, 1'b1, 64'd2000000000, 0, 1'b0, ST_MATCH));
        // widest window, both edges
        add_row(cfg_row(CFG_SKEW, 64'd7));
        add_row(row(ROW_HIT, 20'd0, 1'b1, 64'd2000000000, -7, 1'b0, ST_MATCH));
        add_row(row(ROW_HIT, 20'd0, 1'b1, 64'd2000000000, 7, 1'b0, ST_MATCH));
        // zero step length acts as one second; window clipped at the top of time
        add_row(cfg_row(CFG_STEP, 64'd0));
        add_row(cfg_row(CFG_SKEW, 64'd3));
        add_row(row(ROW_HIT, 20'd0, 1'b1, T_MAX, -3, 1'b0, ST_MATCH));
        add_row(row(ROW_PRED, 20'd0, 1'b1, T_MAX - 64'd1, 0, 1'b0, ST_MATCH));
        // key length above the maximum saturates; longest steps
        add_row(cfg_row(CFG_KEY_LEN, 64'd31));
        add_row(cfg_row(CFG_STEP, 64'd3600));
        add_row(row(ROW_HIT, 20'd0, 1'b1, 64'h0123456789ABCDEF, 1, 1'b0, ST_MATCH));
        add_row(cfg_row(CFG_KEY_LEN, 64'd1));
        add_row(cfg_row(CFG_STEP, 64'd4095));
        add_row(cfg_row(CFG_SKEW, 64'd0));
        add_row(row(ROW_HIT, 20'd0, 1'b1, 64'h8000000000000000, 0, 1'b0, ST_MATCH));
        add_row(row(ROW_PRED, 20'd500000, 1'b1, 64'hFFFFFFFF00000000, 0, 1'b0,
                    ST_MATCH));
    endtask

    // Random time past the sync threshold, with every bit exercised.
    function automatic logic [63:0] synced_time();
        logic [63:0] t;
        case ($urandom_range(2))
            0:       t = {$urandom, $urandom};
            1:       t = 64'd1700000001 + 64'($urandom_range(300000000));
            default: t = T_MAX - 64'($urandom_range(100000));
        endcase
        return (t <= 64'(SYNC_THRESHOLD)) ? t + 64'(SYNC_THRESHOLD) : t;
    endfunction

    task automatic random_item();
        logic [19:0] code;
        logic        well;
        logic [63:0] now, centre;
        int          pick, off;
        pick = $urandom_range(99);
        well = 1'b1;
        now  = synced_time();
        code = 20'($urandom);
        if (pick < 8)
        begin
            // malformed token, anything else random
            well = 1'b0;
            now  = {$urandom, $urandom};
        end
        else if (pick < 14)
            now = ($urandom_range(3) == 0) ? 64'd1700000000 : 64'($urandom_range(1700000000));
        else if (pick >= 22)
        begin
            // well-formed attempt that should land somewhere in the window
            centre = current_step(now);
            off = $urandom_range(2 * int'(skew)) - int'(skew);
            if (off > 0 && centre > T_MAX - 64'(off))
                off = 0;
            code = otp_for_step(centre + 64'(signed'(off)));
            if ($urandom_range(9) == 0)
                code = code ^ 20'd1;
        end
        offer(code, well, now, judge_code(code, well, now));
    endtask

    // ------------------------------------------------------------------
    // Receive side
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_seen    <= 0;
            hold_left    <= 0;
        end
        else if (hold_seen != hold_reqs)
        begin
            // long hold-off: the block keeps its verdict and stalls its input
            hold_seen    <= hold_reqs;
            hold_left    <= 3000;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("verdict with none outstanding: accepted %0d status %0d",
                       out_ch.accepted, out_ch.status);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (out_ch.accepted !== want.acc)
                begin
                    $error("accepted: expected %0d, got %0d", want.acc, out_ch.accepted);
                    mismatches++;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.status);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t r;
        verdict_t v;
        logic [19:0] code;
        mismatches = 0;
        hold_reqs  = 0;
        send_idle  = 14;
        recv_idle  = 77;
        in_ch.valid            = 1'b0;
        in_ch.claimed_code     = '0;
        in_ch.code_well_formed = 1'b0;
        in_ch.unix_seconds     = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_KEY_LOW;
        cfg_data  = '0;
        key_lo   = '0;
        key_mid  = '0;
        key_hi   = '0;
        key_len  = 5'd0;
        step_len = 12'd30;
        skew     = 3'd3;
        rst_n    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        fill_table();
        foreach (dir_tab[i])
        begin
            r = dir_tab[i];
            case (r.kind)
                ROW_CFG:
                begin
                    drain();
                    write_reg(r.idx, r.data);
                end
                ROW_FIXED:
                    offer(r.code, r.well, r.now, '{acc: r.acc, status: r.status});
                ROW_PRED:
                    offer(r.code, r.well, r.now, judge_code(r.code, r.well, r.now));
                default:
                begin
                    code = otp_for_step(current_step(r.now) + 64'(signed'(r.offset)));
                    v = judge_code(code, r.well, r.now);
                    offer(code, r.well, r.now, v);
                end
            endcase
        end

        // random part: six configuration sets, three idling regimes
        for (int set = 0; set < 6; set++)
        begin
            drain();
            send_idle = (set < 2) ? 14 : (set < 4) ? 77 : 0;
            recv_idle = (set < 2) ? 77 : (set < 4) ? 14 : 0;
            write_reg(CFG_KEY_LOW, {$urandom, $urandom});
            write_reg(CFG_KEY_MID, {$urandom, $urandom});
            write_reg(CFG_KEY_HIGH, 64'($urandom));
            case (set)
                0:
                begin
                    write_reg(CFG_KEY_LEN, 64'd20);
                    write_reg(CFG_STEP, 64'd30);
                    write_reg(CFG_SKEW, 64'd1);
                end
                1:
                begin
                    write_reg(CFG_KEY_LEN, 64'($urandom_range(19, 1)));
                    write_reg(CFG_STEP, 64'd1);
                    write_reg(CFG_SKEW, 64'd7);
                end
                2:
                begin
                    write_reg(CFG_KEY_LEN, 64'd31);
                    write_reg(CFG_STEP, 64'd3600);
                    write_reg(CFG_SKEW, 64'd0);
                end
                3:
                begin
                    write_reg(CFG_KEY_LEN, 64'd1);
                    write_reg(CFG_STEP, 64'd4095);
                    write_reg(CFG_SKEW, 64'd2);
                end
                4:
                begin
                    write_reg(CFG_KEY_LEN, 64'($urandom_range(20, 1)));
                    write_reg(CFG_STEP, 64'd0);
                    write_reg(CFG_SKEW, 64'($urandom_range(3)));
                    // stall the output while the sender keeps offering
                    hold_reqs++;
                end
                default:
                begin
                    write_reg(CFG_KEY_LEN, 64'd10);
                    write_reg(CFG_STEP, 64'($urandom_range(3600, 1)));
                    write_reg(CFG_SKEW, 64'd3);
                end
            endcase
            repeat (42) random_item();
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
